@@ rtl/assert_macros.svh @@
// assertion macros used by the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define TRM_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("trm assertion failed");

// next-cycle implication, sampled on clk, off while arst_n is low
`define TRM_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("trm assertion failed");

`endif

@@ rtl/trm_pkg.sv @@
// types, operation codes and constants of the register machine execute block
package trm_pkg;

	localparam int NUM_REGS_DEF = 8;

	localparam logic [2:0] FN_MOV = 3'd0;
	localparam logic [2:0] FN_ADD = 3'd1;
	localparam logic [2:0] FN_SUB = 3'd2;
	localparam logic [2:0] FN_CMP = 3'd3;
	localparam logic [2:0] FN_JEQ = 3'd4;
	localparam logic [2:0] FN_JGT = 3'd5;
	localparam logic [2:0] FN_JLT = 3'd6;

	localparam logic [31:0] CMP_EQ = 32'd1;
	localparam logic [31:0] CMP_GT = 32'd2;
	localparam logic [31:0] CMP_LT = 32'd3;

	typedef struct packed {
		logic [2:0]         func;
		logic [2:0]         dest_reg;
		logic               a_is_reg;
		logic [2:0]         a_reg;
		logic signed [31:0] a_const;
		logic               b_is_reg;
		logic [2:0]         b_reg;
		logic signed [31:0] b_const;
		logic [30:0]        jump_target;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] next_pc;
		logic signed [31:0] flag_value;
		logic               wrote;
		logic [2:0]         write_index;
		logic signed [31:0] write_value;
	} out_item_t;

	// execute results handed back to the top level for state update
	typedef struct packed {
		logic [31:0] pc_new;
		logic [31:0] flag_new;
		logic        mem_we;
		logic [2:0]  mem_idx;
		logic [31:0] mem_val;
	} exec_upd_t;

endpackage

@@ rtl/toy_register_machine_execute.sv @@
// top level: register machine execute block with input stage and result register
//
//  channel  signals                        moves
//  in       in_valid / in_ready / in_item  one decoded instruction item
//  out      out_valid / out_ready / out_item  one result item per instruction
//
// one instruction item per cycle sustained unless out_ready stalls the result register;
// the item waits in the input stage, then executes and updates state in one pass
// general registers live in a small two-read-port memory read at accept time;
// pc and flag are plain registers; reset zeroes them and clears all valid bits
// a stalled result register holds one finished item while the input stage holds the next
module toy_register_machine_execute #(
	parameter int NUM_REGS = trm_pkg::NUM_REGS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  trm_pkg::in_item_t  in_item,
	output logic               out_valid,
	input  logic               out_ready,
	output trm_pkg::out_item_t out_item
);
	import trm_pkg::*;

	// general purpose registers sit below the flag and pc
	localparam int GREGS = NUM_REGS - 2;
	localparam int GW    = (GREGS > 1) ? $clog2(GREGS) : 1;

	// input stage
	logic        vld_s1;
	in_item_t    item_s1;
	logic [31:0] a_raw_s1;
	logic [31:0] b_raw_s1;
	logic        a_hit_s1;
	logic        b_hit_s1;
	logic        a_ok_s1;
	logic        b_ok_s1;
	logic [31:0] byp_s1;

	// architectural state
	logic [31:0] gpr_mem [0:GREGS-1];
	logic [GREGS-1:0] gpr_vld_q;
	logic [31:0] pc_q;
	logic [31:0] flag_q;

	// result register
	logic      out_vld_q;
	out_item_t out_q;

	logic        fire;
	logic        acc;
	logic [GW-1:0] a_addr;
	logic [GW-1:0] b_addr;
	logic [GW-1:0] w_addr;
	logic        a_hit;
	logic        b_hit;
	logic [31:0] a_mem;
	logic [31:0] b_mem;
	exec_upd_t   upd;
	out_item_t   res;

	// execute fires when the input stage holds an item and the result slot frees
	assign fire     = vld_s1 && (!out_vld_q || out_ready);
	assign in_ready = !vld_s1 || fire;
	assign acc      = in_valid && in_ready;

	// memory addresses; out-of-range indexes are decoded away in execute
	assign a_addr = (int'(in_item.a_reg) < GREGS) ? in_item.a_reg[GW-1:0] : '0;
	assign b_addr = (int'(in_item.b_reg) < GREGS) ? in_item.b_reg[GW-1:0] : '0;
	assign w_addr = upd.mem_idx[GW-1:0];

	// forward a write landing at the same edge as the read
	assign a_hit = fire && upd.mem_we && (in_item.a_reg == upd.mem_idx);
	assign b_hit = fire && upd.mem_we && (in_item.b_reg == upd.mem_idx);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	// read ports and operand payload, captured at accept
	always_ff @(posedge clk) begin
		if (acc) begin
			item_s1  <= in_item;
			a_raw_s1 <= gpr_mem[a_addr];
			b_raw_s1 <= gpr_mem[b_addr];
			a_ok_s1  <= gpr_vld_q[a_addr];
			b_ok_s1  <= gpr_vld_q[b_addr];
			a_hit_s1 <= a_hit;
			b_hit_s1 <= b_hit;
			byp_s1   <= upd.mem_val;
		end
	end

	// never-written entries read as zero
	assign a_mem = a_hit_s1 ? byp_s1 : (a_ok_s1 ? a_raw_s1 : 32'd0);
	assign b_mem = b_hit_s1 ? byp_s1 : (b_ok_s1 ? b_raw_s1 : 32'd0);

	trm_exec #(
		.NUM_REGS (NUM_REGS)
	) u_exec (
		.item     (item_s1),
		.a_mem    (a_mem),
		.b_mem    (b_mem),
		.pc_cur   (pc_q),
		.flag_cur (flag_q),
		.upd      (upd),
		.res      (res)
	);

	// write port
	always_ff @(posedge clk) begin
		if (fire && upd.mem_we) begin
			gpr_mem[w_addr] <= upd.mem_val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gpr_vld_q <= '0;
			pc_q      <= '0;
			flag_q    <= '0;
		end else if (fire) begin
			if (upd.mem_we) gpr_vld_q[w_addr] <= 1'b1;
			pc_q   <= upd.pc_new;
			flag_q <= upd.flag_new;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (fire) begin
			out_vld_q <= 1'b1;
		end else if (out_ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_q <= res;
		end
	end

	assign out_valid = out_vld_q;
	assign out_item  = out_q;

endmodule

@@ rtl/trm_exec.sv @@
// single-pass execute logic: operand select, move/add/sub/compare, pc and flag update
module trm_exec #(
	parameter int NUM_REGS = trm_pkg::NUM_REGS_DEF
) (
	input  trm_pkg::in_item_t  item,
	input  logic [31:0]        a_mem,
	input  logic [31:0]        b_mem,
	input  logic [31:0]        pc_cur,
	input  logic [31:0]        flag_cur,
	output trm_pkg::exec_upd_t upd,
	output trm_pkg::out_item_t res
);
	import trm_pkg::*;

	localparam int GREGS    = NUM_REGS - 2;
	localparam int FLAG_IDX = NUM_REGS - 2;
	localparam int PC_IDX   = NUM_REGS - 1;

	logic [31:0] pc_adv;
	logic [31:0] a_val;
	logic [31:0] b_val;
	logic [31:0] val;
	logic        wr_op;
	logic        wr;
	logic [31:0] pc_new;
	logic [31:0] flag_new;

	function automatic logic [31:0] src_sel(input logic is_reg, input logic [2:0] idx,
			input logic [31:0] cval, input logic [31:0] mval,
			input logic [31:0] pcv, input logic [31:0] flagv);
		logic [31:0] r;
		if (!is_reg) begin
			r = cval;
		end else if (int'(idx) == PC_IDX) begin
			r = pcv;
		end else if (int'(idx) == FLAG_IDX) begin
			r = flagv;
		end else if (int'(idx) < GREGS) begin
			r = mval;
		end else begin
			r = '0;
		end
		return r;
	endfunction

	assign pc_adv = pc_cur + 32'd1;
	// sources see the advanced pc
	assign a_val  = src_sel(item.a_is_reg, item.a_reg, item.a_const, a_mem, pc_adv, flag_cur);
	assign b_val  = src_sel(item.b_is_reg, item.b_reg, item.b_const, b_mem, pc_adv, flag_cur);

	always_comb begin
		val      = '0;
		wr_op    = 1'b0;
		pc_new   = pc_adv;
		flag_new = flag_cur;
		case (item.func)
			FN_MOV: begin
				val   = a_val;
				wr_op = 1'b1;
			end
			FN_ADD: begin
				val   = a_val + b_val;
				wr_op = 1'b1;
			end
			FN_SUB: begin
				val   = a_val - b_val;
				wr_op = 1'b1;
			end
			FN_CMP: begin
				if (a_val == b_val) begin
					flag_new = CMP_EQ;
				end else if ($signed(a_val) > $signed(b_val)) begin
					flag_new = CMP_GT;
				end else begin
					flag_new = CMP_LT;
				end
			end
			FN_JEQ: begin
				if (flag_cur == CMP_EQ) pc_new = {1'b0, item.jump_target};
			end
			FN_JGT: begin
				if (flag_cur == CMP_GT) pc_new = {1'b0, item.jump_target};
			end
			FN_JLT: begin
				if (flag_cur == CMP_LT) pc_new = {1'b0, item.jump_target};
			end
			default: begin
			end
		endcase

		wr = wr_op && (int'(item.dest_reg) < NUM_REGS);
		// a write to the pc or flag register overrides the update above
		if (wr && int'(item.dest_reg) == PC_IDX) pc_new = val;
		if (wr && int'(item.dest_reg) == FLAG_IDX) flag_new = val;
	end

	assign upd.pc_new   = pc_new;
	assign upd.flag_new = flag_new;
	assign upd.mem_we   = wr && (int'(item.dest_reg) < GREGS);
	assign upd.mem_idx  = item.dest_reg;
	assign upd.mem_val  = val;

	assign res.next_pc     = pc_new;
	assign res.flag_value  = flag_new;
	assign res.wrote       = wr;
	assign res.write_index = wr ? item.dest_reg : 3'd0;
	assign res.write_value = wr ? val : 32'd0;

endmodule

@@ rtl/trm_checker.sv @@
// port-level checker for the register machine execute block, with its bind
`include "assert_macros.svh"

module trm_checker #(
	parameter int NUM_REGS = trm_pkg::NUM_REGS_DEF
) (
	input logic               clk,
	input logic               arst_n,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input trm_pkg::out_item_t out_item
);
	import trm_pkg::*;

	// a stalled result holds
	`TRM_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_item))

	// an empty result slot never blocks the input side
	`TRM_ASSERT_IMP(a_ready_when_empty, !out_valid, in_ready)

	// an item that wrote nothing reports zero index and value
	`TRM_ASSERT_IMP(a_nowrite_zero, out_valid && !out_item.wrote,
		out_item.write_index == 3'd0 && out_item.write_value == 32'sd0)

	// a write to the pc register is what next_pc shows
	`TRM_ASSERT_IMP(a_pc_write, out_valid && out_item.wrote &&
		int'(out_item.write_index) == NUM_REGS - 1, out_item.next_pc == out_item.write_value)

endmodule

bind toy_register_machine_execute trm_checker #(.NUM_REGS(NUM_REGS)) u_trm_checker (.*);

@@ dv/toy_register_machine_execute_checker.sv @@
// checker for the register machine execute block: predicts each result and compares it
`timescale 1ns / 1ps

module toy_register_machine_execute_checker #(
	parameter int NUM_REGS = trm_pkg::NUM_REGS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_ready,
	input  trm_pkg::in_item_t  in_item,
	input  logic               out_valid,
	input  logic               out_ready,
	input  trm_pkg::out_item_t out_item,
	output int                 fail_count,
	output int                 pending_count
);
	import trm_pkg::*;

	localparam int FLAG_IDX = NUM_REGS - 2;
	localparam int PC_IDX   = NUM_REGS - 1;

	logic [31:0] model_regs [NUM_REGS];
	out_item_t   expected_results [$];
	int          result_num;

	function automatic logic [31:0] read_model_reg(input logic [2:0] idx);
		if (int'(idx) < NUM_REGS)
			return model_regs[idx];
		return 32'd0;
	endfunction

	// executes one instruction on the model state and returns its result
	function automatic out_item_t exec_instr(input in_item_t it);
		out_item_t   res;
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] val;
		logic [31:0] flag;
		logic        wr;
		model_regs[PC_IDX] = model_regs[PC_IDX] + 32'd1;
		a    = it.a_is_reg ? read_model_reg(it.a_reg) : it.a_const;
		b    = it.b_is_reg ? read_model_reg(it.b_reg) : it.b_const;
		flag = model_regs[FLAG_IDX];
		wr   = 1'b0;
		val  = 32'd0;
		case (it.func)
			FN_MOV: begin
				val = a;
				wr  = 1'b1;
			end
			FN_ADD: begin
				val = a + b;
				wr  = 1'b1;
			end
			FN_SUB: begin
				val = a - b;
				wr  = 1'b1;
			end
			FN_CMP: begin
				if (a == b)
					model_regs[FLAG_IDX] = CMP_EQ;
				else if ($signed(a) > $signed(b))
					model_regs[FLAG_IDX] = CMP_GT;
				else
					model_regs[FLAG_IDX] = CMP_LT;
			end
			FN_JEQ: if (flag == CMP_EQ) model_regs[PC_IDX] = {1'b0, it.jump_target};
			FN_JGT: if (flag == CMP_GT) model_regs[PC_IDX] = {1'b0, it.jump_target};
			FN_JLT: if (flag == CMP_LT) model_regs[PC_IDX] = {1'b0, it.jump_target};
			default: ;
		endcase
		if (wr && int'(it.dest_reg) < NUM_REGS) begin
			model_regs[it.dest_reg] = val;
		end else begin
			wr  = 1'b0;
			val = 32'd0;
		end
		res.next_pc     = model_regs[PC_IDX];
		res.flag_value  = model_regs[FLAG_IDX];
		res.wrote       = wr;
		res.write_index = wr ? it.dest_reg : 3'd0;
		res.write_value = val;
		return res;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("result %0d: %s got %h want %h", result_num, what, got, want);
		fail_count = fail_count + 1;
	endtask

	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++)
				model_regs[i] = 32'd0;
			expected_results.delete();
			result_num = 0;
			fail_count = 0;
			pending_count <= 0;
		end else begin
			if (in_valid && in_ready)
				expected_results.insert(expected_results.size(), exec_instr(in_item));
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					report_mismatch("unexpected result, next_pc", out_item.next_pc, 32'd0);
				end else begin
					want = expected_results.pop_front();
					if (out_item.next_pc !== want.next_pc)
						report_mismatch("next_pc", out_item.next_pc, want.next_pc);
					if (out_item.flag_value !== want.flag_value)
						report_mismatch("flag_value", out_item.flag_value, want.flag_value);
					if (out_item.wrote !== want.wrote)
						report_mismatch("wrote", 32'(out_item.wrote), 32'(want.wrote));
					if (out_item.write_index !== want.write_index)
						report_mismatch("write_index", 32'(out_item.write_index),
							32'(want.write_index));
					if (out_item.write_value !== want.write_value)
						report_mismatch("write_value", out_item.write_value, want.write_value);
				end
				result_num = result_num + 1;
			end
			pending_count <= expected_results.size();
		end
	end

endmodule

@@ dv/toy_register_machine_execute_test.sv @@
// testbench top for the register machine execute block: stimulus, handshakes and verdict
`timescale 1ns / 1ps

module toy_register_machine_execute_test;
	import trm_pkg::*;

	// code with no operation behind it, only advances the counter
	localparam logic [2:0] FN_NOP = 3'd7;
	localparam int RANDOM_ITEMS = 700;

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      in_valid  = 1'b0;
	logic      in_ready;
	in_item_t  in_item   = '0;
	logic      out_valid;
	logic      out_ready = 1'b0;
	out_item_t out_item;
	int        fail_count;
	int        pending_count;

	// set during stretches where neither side idles
	bit        no_gaps = 1'b0;

	in_item_t  directed_items [$];

	always #5 clk = ~clk;

	toy_register_machine_execute dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

	toy_register_machine_execute_checker checker_i (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.in_item       (in_item),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.out_item      (out_item),
		.fail_count    (fail_count),
		.pending_count (pending_count)
	);

	// builds one decoded instruction
	function automatic in_item_t make_instr(input logic [2:0] func, input logic [2:0] dest,
			input logic a_is_reg, input logic [2:0] a_reg, input logic [31:0] a_const,
			input logic b_is_reg, input logic [2:0] b_reg, input logic [31:0] b_const,
			input logic [30:0] target);
		in_item_t it;
		it.func        = func;
		it.dest_reg    = dest;
		it.a_is_reg    = a_is_reg;
		it.a_reg       = a_reg;
		it.a_const     = a_const;
		it.b_is_reg    = b_is_reg;
		it.b_reg       = b_reg;
		it.b_const     = b_const;
		it.jump_target = target;
		return it;
	endfunction

	// appends one item to the directed list
	function automatic void queue_item(input in_item_t it);
		directed_items.insert(directed_items.size(), it);
	endfunction

	// constants mix small values so compares hit equal often, the extremes and random words
	function automatic logic [31:0] rand_const();
		int unsigned pick;
		pick = $urandom_range(0, 3);
		case (pick)
			0: return 32'($signed($urandom_range(0, 6)) - 3);
			1: begin
				case ($urandom_range(0, 3))
					0: return 32'h7fff_ffff;
					1: return 32'h8000_0000;
					2: return 32'hffff_ffff;
					default: return 32'h0000_0000;
				endcase
			end
			default: return $urandom();
		endcase
	endfunction

	// mostly arithmetic and compare/jump mixes, a little of the unused code as noise
	function automatic in_item_t rand_instr();
		in_item_t    it;
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 15)      it.func = FN_MOV;
		else if (pick < 30) it.func = FN_ADD;
		else if (pick < 45) it.func = FN_SUB;
		else if (pick < 65) it.func = FN_CMP;
		else if (pick < 75) it.func = FN_JEQ;
		else if (pick < 85) it.func = FN_JGT;
		else if (pick < 95) it.func = FN_JLT;
		else                it.func = FN_NOP;
		it.dest_reg    = 3'($urandom_range(0, 7));
		it.a_is_reg    = 1'($urandom_range(0, 1));
		it.a_reg       = 3'($urandom_range(0, 7));
		it.a_const     = rand_const();
		it.b_is_reg    = 1'($urandom_range(0, 1));
		it.b_reg       = 3'($urandom_range(0, 7));
		it.b_const     = rand_const();
		it.jump_target = 31'($urandom());
		return it;
	endfunction

	// offers one item after a random gap and holds it until accepted
	task automatic send_instr(input in_item_t it);
		int unsigned gap;
		gap = no_gaps ? 0 : $urandom_range(0, 5);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_item  <= it;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	// result side: random stall before each item, then ready until one is taken
	initial begin
		int unsigned stall;
		do @(posedge clk); while (!arst_n);
		forever begin
			stall = no_gaps ? 0 : $urandom_range(0, 5);
			if (stall != 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
		end
	end

	// watchdog for a hung handshake
	initial begin
		#2_000_000;
		$display("toy_register_machine_execute: mismatch");
		$finish;
	end

	initial begin
		// reset held low from the start, released on an edge
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// extremes, wraparound, every operation, taken and not-taken jumps
		queue_item(make_instr(FN_MOV, 0, 0, 0, 32'h7fff_ffff, 0, 0, 0, 0));
		queue_item(make_instr(FN_MOV, 1, 0, 0, 32'h8000_0000, 0, 0, 0, 0));
		// add overflow and subtract underflow
		queue_item(make_instr(FN_ADD, 2, 1, 0, 0, 0, 0, 32'd1, 0));
		queue_item(make_instr(FN_SUB, 3, 1, 1, 0, 0, 0, 32'd1, 0));
		queue_item(make_instr(FN_ADD, 4, 0, 0, 32'hffff_ffff, 0, 0,
			32'hffff_ffff, 0));
		// signed compare: max vs min is greater, then a taken jump to the top target
		queue_item(make_instr(FN_CMP, 0, 1, 0, 0, 1, 1, 0, 0));
		queue_item(make_instr(FN_JGT, 0, 0, 0, 0, 0, 0, 0, 31'h7fff_ffff));
		queue_item(make_instr(FN_JEQ, 0, 0, 0, 0, 0, 0, 0, 31'd55));
		queue_item(make_instr(FN_CMP, 0, 1, 1, 0, 1, 0, 0, 0));
		queue_item(make_instr(FN_JLT, 0, 0, 0, 0, 0, 0, 0, 31'd0));
		queue_item(make_instr(FN_CMP, 0, 1, 0, 0, 1, 0, 0, 0));
		queue_item(make_instr(FN_JEQ, 0, 0, 0, 0, 0, 0, 0, 31'd12345));
		queue_item(make_instr(FN_JLT, 0, 0, 0, 0, 0, 0, 0, 31'd77));
		// reading the counter sees the advanced value
		queue_item(make_instr(FN_MOV, 5, 1, 7, 0, 0, 0, 0, 0));
		// writing the flag register directly steers the next jump
		queue_item(make_instr(FN_MOV, 6, 0, 0, CMP_GT, 0, 0, 0, 0));
		queue_item(make_instr(FN_JGT, 0, 0, 0, 0, 0, 0, 0, 31'd3));
		// writing the counter, then the counter wraps on the next item
		queue_item(make_instr(FN_MOV, 7, 0, 0, 32'hffff_ffff, 0, 0, 0, 0));
		queue_item(make_instr(FN_NOP, 0, 0, 0, 0, 0, 0, 0, 0));
		queue_item(make_instr(FN_ADD, 7, 1, 7, 0, 0, 0, 32'd10, 0));
		queue_item(make_instr(FN_SUB, 0, 1, 6, 0, 1, 5, 0, 0));
		queue_item(make_instr(FN_CMP, 0, 0, 0, 32'h8000_0000, 0, 0,
			32'h7fff_ffff, 0));
		queue_item(make_instr(FN_MOV, 2, 1, 6, 0, 0, 0, 0, 0));
		queue_item(make_instr(FN_CMP, 0, 1, 4, 0, 0, 0, 32'hffff_fffe, 0));
		// unused code with every other field at all ones
		queue_item(make_instr(FN_NOP, 7, 1, 7, 32'hffff_ffff, 1, 7,
			32'hffff_ffff, 31'h7fff_ffff));
		queue_item(make_instr(FN_ADD, 6, 1, 6, 0, 1, 6, 0, 0));
		foreach (directed_items[i])
			send_instr(directed_items[i]);

		// random instruction stream with gap-free stretches and one full drain
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			no_gaps = (i >= 100 && i < 200) || (i >= 500 && i < 560);
			if (i == 350) begin
				in_valid <= 1'b0;
				do @(negedge clk); while (pending_count != 0);
				@(posedge clk);
			end
			send_instr(rand_instr());
		end
		in_valid <= 1'b0;

		// drain, then give a stray result time to show up
		do @(negedge clk); while (pending_count != 0);
		repeat (20) @(posedge clk);
		@(negedge clk);
		if (fail_count == 0)
			$display("toy_register_machine_execute: match");
		else
			$display("toy_register_machine_execute: mismatch");
		$finish;
	end

endmodule
